[sv/gcb_pkg.sv]
// shared types and constants of the cell blitter
`timescale 1ns / 1ps

package gcb_pkg;

  localparam int TYPE_W        = 3;
  localparam int COORD_W       = 11;
  localparam int CODE_W        = 8;
  localparam int CLASS_W       = 2;
  localparam int INDEX_W       = 13;
  localparam int DATA_W        = 16;
  localparam int THEME_W       = 3;
  localparam int ADDR_W        = 17;
  localparam int COLOR_W       = 16;
  localparam int TILE_W        = 8;
  localparam int CELL_MAX_W    = 8;
  localparam int PAL_ADDR_MAX_W = 9;

  localparam int GLYPH_BASE    = 32;
  localparam int BORDER_BASE   = 96;
  localparam int TEXT_PAL_OFS  = 2;
  localparam int BG_PAL_OFS    = 9;
  localparam int FILL_COLOR    = 2;
  localparam int CELL_PIXELS   = 64;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD_TILE = 3'd0,
    REQ_LOAD_PAL  = 3'd1,
    REQ_FILL      = 3'd2,
    REQ_GLYPH     = 3'd3,
    REQ_BORDER    = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    OP_LOAD_TILE,
    OP_LOAD_PAL,
    OP_DRAW
  } cmd_op_t;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_TILE,
    MODE_SKIP
  } draw_mode_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DRAW
  } back_state_t;

  typedef struct packed {
    cmd_op_t                    op;
    draw_mode_t                 mode;
    logic [COORD_W-1:0]         cell_x;
    logic [COORD_W-1:0]         cell_y;
    logic [CELL_MAX_W-1:0]      cell_num;
    logic [PAL_ADDR_MAX_W-1:0]  pal_base;
    logic [INDEX_W-1:0]         load_index;
    logic [DATA_W-1:0]          load_data;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               we;
    logic               last;
  } res_t;

endpackage

[sv/gcb_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module gcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gcb_fifo.sv]
// small register fifo with occupancy count
`timescale 1ns / 1ps

module gcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign count   = cnt;
  assign dout    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[sv/gcb_front.sv]
// front end: theme register, request accept and classification into commands
`timescale 1ns / 1ps

module gcb_front #(
  parameter int COLORS_PER_PALETTE = 8,
  parameter int NUM_PALETTES       = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcb_pkg::THEME_W-1:0]       cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [gcb_pkg::TYPE_W-1:0]        req_type,
  input  logic signed [gcb_pkg::COORD_W-1:0] cell_x,
  input  logic signed [gcb_pkg::COORD_W-1:0] cell_y,
  input  logic signed [gcb_pkg::CODE_W-1:0] glyph_code,
  input  logic [gcb_pkg::CLASS_W-1:0]       col_class,
  input  logic [gcb_pkg::CLASS_W-1:0]       row_class,
  input  logic [gcb_pkg::INDEX_W-1:0]       load_index,
  input  logic [gcb_pkg::DATA_W-1:0]        load_data,
  input  logic                              q_full,
  input  logic                              busy,
  output logic                              q_push,
  output gcb_pkg::cmd_t                     q_data
);

  localparam int PNUM_W = 6;
  localparam int PW     = gcb_pkg::PAL_ADDR_MAX_W;
  localparam int CW     = gcb_pkg::CELL_MAX_W;
  localparam int CLW    = gcb_pkg::CLASS_W;

  logic [gcb_pkg::THEME_W-1:0] theme;
  logic                        cmd_valid;
  logic [PNUM_W-1:0]           pnum;
  logic [PNUM_W-1:0]           pal_sel;
  logic [CLW-1:0]              row_c;
  logic [CLW-1:0]              col_c;
  logic                        low_code;

  assign cfg_ready = 1'b1;
  assign full      = q_full || busy;
  assign q_push    = push && !full && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      theme <= '0;
    end else if (cfg_valid) begin
      theme <= cfg_data;
    end
  end

  always_comb begin
    row_c    = (row_class == CLW'(3)) ? CLW'(2) : row_class;
    col_c    = (col_class == CLW'(3)) ? CLW'(2) : col_class;
    low_code = glyph_code[gcb_pkg::CODE_W-1] || (glyph_code[6:5] == 2'b00);

    if (req_type == gcb_pkg::REQ_FILL) begin
      pnum = PNUM_W'(theme) + PNUM_W'(gcb_pkg::BG_PAL_OFS);
    end else begin
      pnum = PNUM_W'(theme) + PNUM_W'(gcb_pkg::TEXT_PAL_OFS);
    end
    // palette number wraps at most once
    pal_sel = (pnum >= PNUM_W'(NUM_PALETTES)) ? pnum - PNUM_W'(NUM_PALETTES) : pnum;

    cmd_valid         = 1'b0;
    q_data.op         = gcb_pkg::OP_DRAW;
    q_data.mode       = gcb_pkg::MODE_TILE;
    q_data.cell_x     = cell_x;
    q_data.cell_y     = cell_y;
    q_data.cell_num   = '0;
    q_data.pal_base   = PW'(PW'(pal_sel) * PW'(COLORS_PER_PALETTE));
    q_data.load_index = load_index;
    q_data.load_data  = load_data;

    unique case (gcb_pkg::req_type_t'(req_type))
      gcb_pkg::REQ_LOAD_TILE: begin
        cmd_valid = 1'b1;
        q_data.op = gcb_pkg::OP_LOAD_TILE;
      end
      gcb_pkg::REQ_LOAD_PAL: begin
        cmd_valid = 1'b1;
        q_data.op = gcb_pkg::OP_LOAD_PAL;
      end
      gcb_pkg::REQ_FILL: begin
        cmd_valid   = 1'b1;
        q_data.mode = gcb_pkg::MODE_FILL;
      end
      gcb_pkg::REQ_GLYPH: begin
        cmd_valid       = 1'b1;
        q_data.cell_num = low_code ? '0 : CW'(glyph_code) - CW'(gcb_pkg::GLYPH_BASE);
      end
      gcb_pkg::REQ_BORDER: begin
        cmd_valid       = 1'b1;
        q_data.cell_num = CW'(gcb_pkg::BORDER_BASE) + CW'(row_c) * CW'(3) + CW'(col_c);
        // centre cell draws nothing
        if (row_c == CLW'(1) && col_c == CLW'(1)) begin
          q_data.mode = gcb_pkg::MODE_SKIP;
        end
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

[sv/gcb_back.sv]
// back end: store clear, loads and the per-pixel draw pipeline with result queue
`timescale 1ns / 1ps

module gcb_back #(
  parameter int FRAME_WIDTH        = 320,
  parameter int FRAME_HEIGHT       = 240,
  parameter int NUM_CELLS          = 128,
  parameter int COLORS_PER_PALETTE = 8,
  parameter int NUM_PALETTES       = 16,
  parameter int RES_DEPTH          = 4
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          q_empty,
  input  gcb_pkg::cmd_t q_data,
  output logic          q_pop,
  input  logic          res_pop,
  output logic          res_empty,
  output gcb_pkg::res_t res_data
);

  localparam int TILE_DEPTH = NUM_CELLS * gcb_pkg::CELL_PIXELS;
  localparam int TILE_AW    = $clog2(TILE_DEPTH);
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int PAL_DEPTH  = NUM_PALETTES * COLORS_PER_PALETTE;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int CIDX_W     = $clog2(COLORS_PER_PALETTE);
  localparam int X_W        = $clog2(FRAME_WIDTH);
  localparam int Y_W        = $clog2(FRAME_HEIGHT);
  localparam int PROD_W     = $clog2(FRAME_WIDTH * FRAME_HEIGHT) + 1;
  localparam int CNT_W      = $clog2(RES_DEPTH + 1);
  localparam int CRD_W      = CNT_W + 1;
  localparam int XW         = gcb_pkg::COORD_W;
  localparam int AW         = gcb_pkg::ADDR_W;
  localparam int TW         = gcb_pkg::TILE_W;
  localparam int TAB_N      = 1 << TW;

  function automatic logic [TAB_N*CIDX_W-1:0] build_mod_tab();
    logic [TAB_N*CIDX_W-1:0] t;
    t = '0;
    for (int n = 0; n < TAB_N; n++) begin
      t[n*CIDX_W +: CIDX_W] = CIDX_W'(n % COLORS_PER_PALETTE);
    end
    return t;
  endfunction

  localparam logic [TAB_N*CIDX_W-1:0] MOD_TAB = build_mod_tab();

  gcb_pkg::back_state_t state, state_next;

  logic [TILE_AW-1:0]        clr_addr;
  logic [5:0]                k;
  logic                      load_draw;
  logic                      issue;
  logic                      credit_ok;
  logic [CNT_W-1:0]          res_count;
  logic                      res_full;
  gcb_pkg::res_t             res_in;
  logic [$bits(gcb_pkg::res_t)-1:0] res_raw;

  logic [XW-1:0]             d_x;
  logic [XW-1:0]             d_y;
  logic [CELL_W-1:0]         d_cell;
  logic [PAL_AW-1:0]         d_base;
  gcb_pkg::draw_mode_t       d_mode;

  logic [XW:0]               sx;
  logic [XW:0]               sy;
  logic                      on;

  logic                      tile_we;
  logic [TILE_AW-1:0]        tile_waddr;
  logic [TW-1:0]             tile_wdata;
  logic [TILE_AW-1:0]        tile_raddr;
  logic [TW-1:0]             tile_rdata;
  logic                      pal_we;
  logic [PAL_AW-1:0]         pal_waddr;
  logic [gcb_pkg::COLOR_W-1:0] pal_wdata;
  logic [PAL_AW-1:0]         pal_raddr;
  logic [gcb_pkg::COLOR_W-1:0] pal_rdata;

  logic                      s1_valid;
  logic                      s1_on;
  logic [X_W-1:0]            s1_x;
  logic [Y_W-1:0]            s1_y;
  gcb_pkg::draw_mode_t       s1_mode;
  logic [PAL_AW-1:0]         s1_base;
  logic                      s1_last;
  logic [CIDX_W-1:0]         cidx;
  logic                      we1;
  logic [AW-1:0]             addr1;

  logic                      s2_valid;
  logic [AW-1:0]             s2_addr;
  logic                      s2_we;
  logic                      s2_last;

  assign busy = (state == gcb_pkg::BK_CLEAR);

  // in-flight pixels always find room in the result queue
  assign credit_ok = (CRD_W'(res_count) + CRD_W'(s1_valid) + CRD_W'(s2_valid))
                     < CRD_W'(RES_DEPTH);
  assign issue     = (state == gcb_pkg::BK_DRAW) && credit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcb_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_draw  = 1'b0;
    tile_we    = 1'b0;
    tile_waddr = TILE_AW'(q_data.load_index);
    tile_wdata = q_data.load_data[TW-1:0];
    pal_we     = 1'b0;
    pal_waddr  = PAL_AW'(q_data.load_index);
    pal_wdata  = q_data.load_data;
    unique case (state)
      gcb_pkg::BK_CLEAR: begin
        tile_we    = 1'b1;
        tile_waddr = clr_addr;
        tile_wdata = '0;
        pal_we     = (32'(clr_addr) < 32'(PAL_DEPTH));
        pal_waddr  = PAL_AW'(clr_addr);
        pal_wdata  = '0;
        if (clr_addr == TILE_AW'(TILE_DEPTH - 1)) begin
          state_next = gcb_pkg::BK_IDLE;
        end
      end
      gcb_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.op)
            gcb_pkg::OP_LOAD_TILE: begin
              tile_we = (32'(q_data.load_index) < 32'(TILE_DEPTH));
            end
            gcb_pkg::OP_LOAD_PAL: begin
              pal_we = (32'(q_data.load_index) < 32'(PAL_DEPTH));
            end
            gcb_pkg::OP_DRAW: begin
              load_draw  = 1'b1;
              state_next = gcb_pkg::BK_DRAW;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      gcb_pkg::BK_DRAW: begin
        if (issue && k == 6'd63) begin
          state_next = gcb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = gcb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      k        <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (state == gcb_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_draw) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_draw) begin
      d_x    <= q_data.cell_x;
      d_y    <= q_data.cell_y;
      d_cell <= q_data.cell_num[CELL_W-1:0];
      d_base <= PAL_AW'(q_data.pal_base);
      d_mode <= q_data.mode;
    end
  end

  // pixel issue: column k[5:3], row k[2:0]
  always_comb begin
    sx         = {d_x[XW-1], d_x} + (XW+1)'(k[5:3]);
    sy         = {d_y[XW-1], d_y} + (XW+1)'(k[2:0]);
    on         = !sx[XW] && (sx[XW-1:0] < XW'(FRAME_WIDTH)) &&
                 !sy[XW] && (sy[XW-1:0] < XW'(FRAME_HEIGHT));
    tile_raddr = {d_cell, k[2:0], k[5:3]};
  end

  always_ff @(posedge clk) begin
    s1_on   <= on;
    s1_x    <= sx[X_W-1:0];
    s1_y    <= sy[Y_W-1:0];
    s1_mode <= d_mode;
    s1_base <= d_base;
    s1_last <= (k == 6'd63);
  end

  always_comb begin
    if (s1_mode == gcb_pkg::MODE_FILL) begin
      cidx = CIDX_W'(gcb_pkg::FILL_COLOR);
    end else begin
      cidx = MOD_TAB[tile_rdata*CIDX_W +: CIDX_W];
    end
    pal_raddr = s1_base + PAL_AW'(cidx);
    we1 = s1_on && ((s1_mode == gcb_pkg::MODE_FILL) ||
                    ((s1_mode == gcb_pkg::MODE_TILE) && (tile_rdata != '0)));
    if (s1_on) begin
      addr1 = AW'(PROD_W'(s1_y) * PROD_W'(FRAME_WIDTH) + PROD_W'(s1_x));
    end else begin
      addr1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr <= addr1;
    s2_we   <= we1;
    s2_last <= s1_last;
  end

  always_comb begin
    res_in.addr  = s2_addr;
    res_in.color = s2_we ? pal_rdata : '0;
    res_in.we    = s2_we;
    res_in.last  = s2_last;
  end

  gcb_ram #(
    .WIDTH (TW),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

  gcb_ram #(
    .WIDTH (gcb_pkg::COLOR_W),
    .DEPTH (PAL_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  gcb_fifo #(
    .WIDTH ($bits(gcb_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid),
    .din   (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .dout  (res_raw),
    .empty (res_empty),
    .count (res_count)
  );

  assign res_data = gcb_pkg::res_t'(res_raw);

endmodule

[sv/gui_cell_blitter_core.sv]
// top level of the 8x8 cell blitter with tile and palette stores
//
// input channel: push/full; one transaction carries a load or a draw request.
//   tile and palette loads retire one at a time from the idle state; a draw
//   starts there, then runs one pixel per cycle while the result queue has
//   room (tile ram read, palette ram read, result queue).
// result channel: empty/pop; each draw gives 64 pixel transactions, column
//   outer and row inner, last set on the 64th. loads give none.
// a draw's first pixel passes the issue step, the s1 and s2 registers and the
//   result queue before it shows on the result ports; a two-entry command
//   queue between front and back keeps accepting while a draw runs.
// config channel: cfg_valid/cfg_ready, always ready, writes the 3-bit theme.
//   write it only while no draw is pending.
// reset: synchronous, clears the queues and the theme, then a clearing pass
//   over all NUM_CELLS*64 tile ram addresses (8192 by default) zeroes the
//   tile ram and the palette ram; full stays high until the pass ends.
// when pop is held low the result queue fills and the pixel pipeline pauses
//   without loss, then the command queue fills and full rises.
`timescale 1ns / 1ps

module gui_cell_blitter_core #(
  parameter int FRAME_WIDTH        = 320,
  parameter int FRAME_HEIGHT       = 240,
  parameter int NUM_CELLS          = 128,
  parameter int COLORS_PER_PALETTE = 8,
  parameter int NUM_PALETTES       = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcb_pkg::THEME_W-1:0]        cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [gcb_pkg::TYPE_W-1:0]         req_type,
  input  logic signed [gcb_pkg::COORD_W-1:0] cell_x,
  input  logic signed [gcb_pkg::COORD_W-1:0] cell_y,
  input  logic signed [gcb_pkg::CODE_W-1:0]  glyph_code,
  input  logic [gcb_pkg::CLASS_W-1:0]        col_class,
  input  logic [gcb_pkg::CLASS_W-1:0]        row_class,
  input  logic [gcb_pkg::INDEX_W-1:0]        load_index,
  input  logic [gcb_pkg::DATA_W-1:0]         load_data,
  output logic                               empty,
  input  logic                               pop,
  output logic [gcb_pkg::ADDR_W-1:0]         pixel_addr,
  output logic [gcb_pkg::COLOR_W-1:0]        pixel_color,
  output logic                               write_enable,
  output logic                               last
);

  localparam int CMD_DEPTH = 2;

  logic                             q_push;
  gcb_pkg::cmd_t                    q_in;
  logic                             q_full;
  logic                             q_pop;
  logic [$bits(gcb_pkg::cmd_t)-1:0] q_raw;
  gcb_pkg::cmd_t                    q_out;
  logic                             q_empty;
  logic                             busy;
  gcb_pkg::res_t                    res;

  gcb_front #(
    .COLORS_PER_PALETTE (COLORS_PER_PALETTE),
    .NUM_PALETTES       (NUM_PALETTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .glyph_code (glyph_code),
    .col_class  (col_class),
    .row_class  (row_class),
    .load_index (load_index),
    .load_data  (load_data),
    .q_full     (q_full),
    .busy       (busy),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  gcb_fifo #(
    .WIDTH ($bits(gcb_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_raw),
    .empty (q_empty),
    .count ()
  );

  assign q_out = gcb_pkg::cmd_t'(q_raw);

  gcb_back #(
    .FRAME_WIDTH        (FRAME_WIDTH),
    .FRAME_HEIGHT       (FRAME_HEIGHT),
    .NUM_CELLS          (NUM_CELLS),
    .COLORS_PER_PALETTE (COLORS_PER_PALETTE),
    .NUM_PALETTES       (NUM_PALETTES),
    .RES_DEPTH          (4)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res_data  (res)
  );

  assign pixel_addr   = res.addr;
  assign pixel_color  = res.color;
  assign write_enable = res.we;
  assign last         = res.last;

endmodule

[sv/gcb_checker.sv]
// port-level assertions for the cell blitter, bound to the top level
`timescale 1ns / 1ps

module gcb_checker #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [gcb_pkg::ADDR_W-1:0] pixel_addr,
  input logic [gcb_pkg::COLOR_W-1:0] pixel_color,
  input logic                       write_enable,
  input logic                       last
);

  // reset leaves no result and starts the store clearing pass
  a_reset_state: assert property (@(posedge clk) rst |=> empty && full)
    else $error("results or input readiness present right after reset");

  // a masked pixel carries no color
  a_masked_color: assert property (@(posedge clk) disable iff (rst)
    !empty && !write_enable |-> pixel_color == '0)
    else $error("masked pixel with nonzero color");

  // a written pixel lands inside the frame
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    !empty && write_enable |-> 32'(pixel_addr) < FRAME_WIDTH * FRAME_HEIGHT)
    else $error("written pixel outside the frame");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel_addr) && $stable(pixel_color) &&
                       $stable(write_enable) && $stable(last))
    else $error("stalled result changed");

endmodule

bind gui_cell_blitter_core gcb_checker #(
  .FRAME_WIDTH  (FRAME_WIDTH),
  .FRAME_HEIGHT (FRAME_HEIGHT)
) u_checker (.*);
